### src/graph_dfs_path_finder_core_macros.svh
// assertion macros shared by the path finder rtl
// no dependencies; expects clk and rst_n in the including module

`ifndef GRAPH_DFS_PATH_FINDER_CORE_MACROS_SVH
`define GRAPH_DFS_PATH_FINDER_CORE_MACROS_SVH

// same-cycle implication, idle during reset
`define GDFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define GDFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/gdfs_pkg.sv
// shared types and constants for the depth-first path finder
// no dependencies
`timescale 1ns / 1ps

package gdfs_pkg;

  localparam int NODE_COUNT  = 32;
  localparam int MAX_DEGREE  = 8;
  localparam int NODE_W      = 5;
  localparam int SLOT_W      = 3;
  localparam int DEG_W       = 4;
  localparam int SP_W        = $clog2(NODE_COUNT + 1);
  localparam int TABLE_DEPTH = NODE_COUNT * MAX_DEGREE;
  localparam int TABLE_AW    = NODE_W + SLOT_W;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DEGREE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FOUND = 2'd1,
    KIND_PATH  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_ENTER,
    ST_FOUND,
    ST_CHK,
    ST_LOOP,
    ST_NB,
    ST_DONE
  } state_t;

  // operands of the shared compare unit
  typedef struct packed {
    logic [NODE_W-1:0] probe;
    logic [NODE_W-1:0] target;
    logic [DEG_W-1:0]  slot;
    logic [DEG_W-1:0]  degree;
  } cmp_req_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic probe_marked;
    logic target_marked;
    logic probe_is_target;
    logic slot_left;
    logic deg_is_one;
  } cmp_res_t;

  // one result item
  typedef struct packed {
    kind_t             kind;
    logic [NODE_W-1:0] node;
    logic              success;
    logic              last;
  } out_item_t;

endpackage

### src/graph_dfs_path_finder_core.sv
// top level of the depth-first path finder: sequencer, graph state and stack
// depends on gdfs_pkg, gdfs_ram, gdfs_cmp_unit, gdfs_out_stage and the macro header
//
// channel | direction | payload
// in_     | sink      | tuser: operation; tdata: node, slot, neighbor, degree, target
// out_    | source    | tuser: kind; tdata: node, success; tlast: last of the item
//
// load, degree and clear items wait in the ack state until the output is free
// a search enters the start node, reads each neighbor slot in the loop state,
// tests it in the neighbor state, enters new nodes through enter and check,
// pops finished frames in the loop state and ends in done after the empty-stack
// check or a failing start; steps share one compare unit and one ram read port
// rst_n clears degrees, visited marks, the stack pointer and the sequencer
// a full output register pauses the sequencer; no item is taken until done

`timescale 1ns / 1ps
`include "graph_dfs_path_finder_core_macros.svh"

module graph_dfs_path_finder_core import gdfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [4:0] node_index, [7:5] slot_index,
                                  // [12:8] neighbor, [16:13] degree,
                                  // [21:17] target_node, [23:22] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] node, [5] success, [7:6] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  // input fields
  op_t               in_op;
  logic [NODE_W-1:0] in_node;
  logic [SLOT_W-1:0] in_slot;
  logic [NODE_W-1:0] in_nb;
  logic [DEG_W-1:0]  in_deg;
  logic [NODE_W-1:0] in_target;

  assign in_op     = op_t'(in_tuser);
  assign in_node   = in_tdata[4:0];
  assign in_slot   = in_tdata[7:5];
  assign in_nb     = in_tdata[12:8];
  assign in_deg    = in_tdata[16:13];
  assign in_target = in_tdata[21:17];

  // state
  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] cur_r;
  logic [NODE_W-1:0] target_r;
  logic              ok_r;
  logic [SP_W-1:0]   sp_r;
  logic [NODE_COUNT-1:0] visited_r;
  logic [DEG_W-1:0]  degree_r [NODE_COUNT];
  logic [NODE_W-1:0] stack_node_r [NODE_COUNT];
  logic [DEG_W-1:0]  stack_slot_r [NODE_COUNT];

  // datapath wires
  logic              accept;
  logic [SP_W-1:0]   sp_dec;
  logic [NODE_W-1:0] top_idx;
  logic [NODE_W-1:0] top_node;
  logic [DEG_W-1:0]  top_slot;
  logic              sp_zero;
  logic [NODE_W-1:0] deg_node;
  logic [NODE_W-1:0] ram_rdata;
  logic              ram_we;
  logic [TABLE_AW-1:0] ram_waddr;
  logic              ram_re;
  logic [TABLE_AW-1:0] ram_raddr;
  cmp_req_t          cmp_req;
  cmp_res_t          cmp_res;
  logic              emit_ok;
  logic              emit;
  out_item_t         emit_item;
  logic              push_frame;
  logic              adv_slot;
  logic              pop_frame;
  logic              chk_fail;

  assign in_tready = (state_r == ST_IDLE) && rst_n;
  assign accept    = in_tvalid && in_tready;

  // top of stack
  assign sp_dec   = sp_r - 1'b1;
  assign top_idx  = sp_dec[NODE_W-1:0];
  assign top_node = stack_node_r[top_idx];
  assign top_slot = stack_slot_r[top_idx];
  assign sp_zero  = (sp_r == '0);

  // shared compare unit operand selection
  assign deg_node = (state_r == ST_LOOP) ? top_node : cur_r;
  assign cmp_req.probe  = (state_r == ST_ENTER) ? cur_r : ram_rdata;
  assign cmp_req.target = target_r;
  assign cmp_req.slot   = top_slot;
  assign cmp_req.degree = degree_r[deg_node];

  gdfs_cmp_unit u_cmp (
    .visited (visited_r),
    .req     (cmp_req),
    .res     (cmp_res)
  );

  assign chk_fail = cmp_res.deg_is_one && cmp_res.probe_marked;

  // neighbor table
  assign ram_we    = accept && (in_op == OP_WRITE);
  assign ram_waddr = {in_node, in_slot};

  gdfs_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_nb),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gdfs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (emit),
    .item       (emit_item),
    .free       (emit_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == OP_SEARCH) ? ST_ENTER : ST_ACK;
        end
      end
      ST_ACK: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ENTER: begin
        state_nxt = cmp_res.probe_is_target ? ST_FOUND : ST_CHK;
      end
      ST_FOUND: begin
        if (emit_ok) begin
          state_nxt = ST_LOOP;
        end
      end
      ST_CHK: begin
        state_nxt = (chk_fail && sp_zero) ? ST_DONE : ST_LOOP;
      end
      ST_LOOP: begin
        if (sp_zero) begin
          state_nxt = ST_DONE;
        end else if (cmp_res.slot_left) begin
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        state_nxt = (!cmp_res.probe_marked && !cmp_res.target_marked) ? ST_ENTER : ST_LOOP;
      end
      ST_DONE: begin
        if (emit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    emit              = 1'b0;
    emit_item.kind    = KIND_ACK;
    emit_item.node    = '0;
    emit_item.success = 1'b0;
    emit_item.last    = 1'b0;
    ram_re            = 1'b0;
    ram_raddr         = {top_node, top_slot[SLOT_W-1:0]};
    push_frame        = 1'b0;
    adv_slot          = 1'b0;
    pop_frame         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_ACK: begin
        emit           = emit_ok;
        emit_item.last = 1'b1;
      end
      ST_ENTER: begin
        ram_re    = !cmp_res.probe_is_target;
        ram_raddr = {cur_r, {SLOT_W{1'b0}}};
      end
      ST_FOUND: begin
        emit           = emit_ok;
        emit_item.kind = KIND_FOUND;
        emit_item.node = cur_r;
      end
      ST_CHK: begin
        push_frame = !chk_fail;
      end
      ST_LOOP: begin
        if (!sp_zero) begin
          if (cmp_res.slot_left) begin
            ram_re   = 1'b1;
            adv_slot = 1'b1;
          end else if (cmp_res.target_marked) begin
            // unwinding past the target: report the node on the way out
            emit           = emit_ok;
            emit_item.kind = KIND_PATH;
            emit_item.node = top_node;
            pop_frame      = emit_ok;
          end else begin
            pop_frame = 1'b1;
          end
        end
      end
      ST_NB: begin
      end
      ST_DONE: begin
        emit              = emit_ok;
        emit_item.kind    = KIND_DONE;
        emit_item.success = ok_r;
        emit_item.last    = 1'b1;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // search operands and current node
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r    <= in_node;
      target_r <= in_target;
    end else if (state_r == ST_NB) begin
      cur_r <= ram_rdata;
    end
  end

  // search outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else if (state_r == ST_CHK && chk_fail && sp_zero) begin
      ok_r <= 1'b0;
    end else if (state_r == ST_LOOP && sp_zero) begin
      ok_r <= cmp_res.target_marked;
    end
  end

  // visited marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
    end else if (accept && in_op == OP_CLEAR) begin
      visited_r <= '0;
    end else if (state_r == ST_ENTER) begin
      visited_r[cur_r] <= 1'b1;
    end
  end

  // node degrees, clamped on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        degree_r[i] <= '0;
      end
    end else if (accept && in_op == OP_DEGREE) begin
      degree_r[in_node] <= (in_deg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : in_deg;
    end
  end

  // stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (push_frame && sp_r < SP_W'(NODE_COUNT)) begin
      sp_r <= sp_r + 1'b1;
    end else if (pop_frame) begin
      sp_r <= sp_dec;
    end
  end

  // stack frames
  always_ff @(posedge clk) begin
    if (push_frame && sp_r < SP_W'(NODE_COUNT)) begin
      stack_node_r[sp_r[NODE_W-1:0]] <= cur_r;
      stack_slot_r[sp_r[NODE_W-1:0]] <= '0;
    end else if (adv_slot) begin
      stack_slot_r[top_idx] <= top_slot + 1'b1;
    end
  end

  // checks
  `GDFS_ASSERT_NOW(a_sp_bound, 1'b1, sp_r <= SP_W'(NODE_COUNT), "stack pointer past depth")
  `GDFS_ASSERT_NOW(a_idle_empty, state_r == ST_IDLE, sp_zero, "idle with frames on stack")
  `GDFS_ASSERT_NEXT(a_enter_marks, state_r == ST_ENTER, visited_r[$past(cur_r)], "entered node not marked")
  `GDFS_ASSERT_NOW(a_done_last, out_tvalid && out_tuser == KIND_DONE, out_tlast, "done without last")
  `GDFS_ASSERT_NEXT(a_pop_emits, pop_frame && cmp_res.target_marked, out_tvalid && out_tuser == KIND_PATH, "pop past target without path item")

endmodule

### src/gdfs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/gdfs_cmp_unit.sv
// shared compare unit: visited lookups, target match and slot/degree checks
// depends on gdfs_pkg
`timescale 1ns / 1ps

module gdfs_cmp_unit import gdfs_pkg::*; (
  input  logic [NODE_COUNT-1:0] visited,
  input  cmp_req_t              req,
  output cmp_res_t              res
);

  // one probe node, the target, and the current frame's slot against its degree
  always_comb begin
    res.probe_marked    = visited[req.probe];
    res.target_marked   = visited[req.target];
    res.probe_is_target = (req.probe == req.target);
    res.slot_left       = (req.slot < req.degree);
    res.deg_is_one      = (req.degree == DEG_W'(1));
  end

endmodule

### src/gdfs_out_stage.sv
// output register of the result channel; frees the sequencer from the sink
// depends on gdfs_pkg
`timescale 1ns / 1ps

module gdfs_out_stage import gdfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t item,
  output logic      free,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_tdata,   // [4:0] node, [5] success, [7:6] zero
  output logic [1:0] out_tuser,   // [1:0] kind
  output logic      out_tlast
);

  logic      valid_r;
  out_item_t item_r;

  assign free = !valid_r || out_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= push;
    end
  end

  // held item
  always_ff @(posedge clk) begin
    if (free && push) begin
      item_r <= item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, item_r.success, item_r.node};
  assign out_tuser  = item_r.kind;
  assign out_tlast  = item_r.last;

endmodule

### test/graph_dfs_path_finder_core_tb.sv
// self-checking testbench for the depth-first path finder core
// depends on gdfs_pkg and graph_dfs_path_finder_core; predicts each result item in place
`timescale 1ns / 1ps

module graph_dfs_path_finder_core_tb;
  import gdfs_pkg::*;

  localparam int CYCLE_LIMIT    = 2000000;
  localparam int TAIL_CYCLES    = 64;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DEG_LIMIT      = 15;

  // one input item as the block sees it
  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] node;
    logic [SLOT_W-1:0] slot;
    logic [NODE_W-1:0] nbr;
    logic [DEG_W-1:0]  deg;
    logic [NODE_W-1:0] tgt;
  } path_req_t;

  // directed row: item plus a typed result where one is obvious
  typedef struct packed {
    path_req_t req;
    logic      typed;
    kind_t     kind;
    logic      ok;
  } plan_row_t;

  localparam int PLAN_LEN = 18;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;   // [4:0] node, [7:5] slot, [12:8] neighbor,
                                      // [16:13] degree, [21:17] target, [23:22] zero
  logic [1:0]        in_tuser = '0;   // [1:0] operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // [4:0] node, [5] success, [7:6] zero
  logic [1:0]        out_tuser;       // [1:0] kind
  logic              out_tlast;

  // predictor copy of the graph and the walk
  logic [NODE_W-1:0]     adj_nbr [NODE_COUNT][MAX_DEGREE] = '{default: '{default: '0}};
  logic [DEG_W-1:0]      adj_deg [NODE_COUNT] = '{default: '0};
  logic [MAX_DEGREE-1:0] slot_loaded [NODE_COUNT] = '{default: '0};
  logic [NODE_COUNT-1:0] visit_mark = '0;
  logic [NODE_W-1:0]     frame_node [NODE_COUNT];
  logic [DEG_W-1:0]      frame_slot [NODE_COUNT];
  int                    frame_top;

  out_item_t         step_results [$];
  out_item_t         awaited_results [$];
  logic [NODE_W-1:0] graph_members [$];

  int   error_count = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   rx_hold_left = 0;
  int   rx_hold_reqs = 0;
  int   rx_hold_seen = 0;

  // directed items: reset state, extremes, the walk rules
  plan_row_t plan [PLAN_LEN] = '{
    '{'{OP_SEARCH, 5'd0,  3'd0, 5'd0,  4'd0, 5'd5},  1'b1, KIND_DONE, 1'b0},
    '{'{OP_CLEAR,  5'd31, 3'd7, 5'd31, 4'd8, 5'd31}, 1'b1, KIND_ACK,  1'b0},
    '{'{OP_WRITE,  5'd0,  3'd0, 5'd1,  4'd0, 5'd0},  1'b1, KIND_ACK,  1'b0},
    '{'{OP_WRITE,  5'd31, 3'd7, 5'd31, 4'd0, 5'd0},  1'b1, KIND_ACK,  1'b0},
    '{'{OP_WRITE,  5'd1,  3'd0, 5'd2,  4'd0, 5'd0},  1'b1, KIND_ACK,  1'b0},
    '{'{OP_WRITE,  5'd1,  3'd1, 5'd0,  4'd0, 5'd0},  1'b1, KIND_ACK,  1'b0},
    '{'{OP_WRITE,  5'd2,  3'd0, 5'd1,  4'd0, 5'd0},  1'b1, KIND_ACK,  1'b0},
    '{'{OP_DEGREE, 5'd0,  3'd0, 5'd0,  4'd1, 5'd0},  1'b1, KIND_ACK,  1'b0},
    '{'{OP_DEGREE, 5'd1,  3'd0, 5'd0,  4'd2, 5'd0},  1'b1, KIND_ACK,  1'b0},
    '{'{OP_DEGREE, 5'd2,  3'd0, 5'd0,  4'd1, 5'd0},  1'b1, KIND_ACK,  1'b0},
    // found, then the path unwinds
    '{'{OP_SEARCH, 5'd0,  3'd0, 5'd0,  4'd0, 5'd2},  1'b0, KIND_ACK,  1'b0},
    // start's single neighbor already visited
    '{'{OP_SEARCH, 5'd0,  3'd0, 5'd0,  4'd0, 5'd2},  1'b0, KIND_ACK,  1'b0},
    // target visited by an earlier search
    '{'{OP_SEARCH, 5'd3,  3'd0, 5'd0,  4'd0, 5'd2},  1'b0, KIND_ACK,  1'b0},
    '{'{OP_CLEAR,  5'd0,  3'd0, 5'd0,  4'd0, 5'd0},  1'b1, KIND_ACK,  1'b0},
    // start is the target
    '{'{OP_SEARCH, 5'd2,  3'd0, 5'd0,  4'd0, 5'd2},  1'b0, KIND_ACK,  1'b0},
    // entered neighbor abandoned by the single-neighbor rule
    '{'{OP_SEARCH, 5'd1,  3'd0, 5'd0,  4'd0, 5'd31}, 1'b0, KIND_ACK,  1'b0},
    '{'{OP_SEARCH, 5'd31, 3'd0, 5'd0,  4'd0, 5'd31}, 1'b0, KIND_ACK,  1'b0},
    '{'{OP_DEGREE, 5'd0,  3'd0, 5'd0,  4'd0, 5'd0},  1'b1, KIND_ACK,  1'b0}
  };

  graph_dfs_path_finder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_reqs != rx_hold_seen) begin
      rx_hold_seen = rx_hold_reqs;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check, sampled mid-cycle so the handshake is settled
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with none expected: kind %0d node %0d", out_tuser, out_tdata[4:0]);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          error_count++;
        end
        if (out_tdata[4:0] !== want.node) begin
          $error("node: expected %0d, got %0d", want.node, out_tdata[4:0]);
          error_count++;
        end
        if (out_tdata[5] !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, out_tdata[5]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  function automatic void stage_result(kind_t kind, logic [NODE_W-1:0] node, logic ok);
    out_item_t r;
    r.kind = kind;
    r.node = node;
    r.success = ok;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  // enter a node: 1 target reached, 0 dropped at once, 2 frame pushed
  function automatic int dfs_enter(logic [NODE_W-1:0] n, logic [NODE_W-1:0] tgt);
    visit_mark[n] = 1'b1;
    if (n == tgt) begin
      stage_result(KIND_FOUND, n, 1'b0);
      return 1;
    end
    if (adj_deg[n] == 1 && visit_mark[adj_nbr[n][0]]) return 0;
    if (frame_top < NODE_COUNT) begin
      frame_node[frame_top] = n;
      frame_slot[frame_top] = '0;
      frame_top++;
    end
    return 2;
  endfunction

  // explicit-stack walk; returns whether the target got marked
  function automatic logic dfs_search(logic [NODE_W-1:0] start, logic [NODE_W-1:0] tgt);
    int                first;
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] nb;
    frame_top = 0;
    first = dfs_enter(start, tgt);
    if (first != 2) return (first == 1);
    while (frame_top > 0) begin
      n = frame_node[frame_top-1];
      if (frame_slot[frame_top-1] < adj_deg[n]) begin
        nb = adj_nbr[n][frame_slot[frame_top-1][SLOT_W-1:0]];
        frame_slot[frame_top-1] = frame_slot[frame_top-1] + 1'b1;
        if (!visit_mark[nb] && !visit_mark[tgt]) void'(dfs_enter(nb, tgt));
      end else begin
        frame_top--;
        if (visit_mark[tgt]) stage_result(KIND_PATH, n, 1'b0);
      end
    end
    return visit_mark[tgt];
  endfunction

  // update the graph copy and stage the result items of one input item
  function automatic void compute_path_items(path_req_t req);
    out_item_t r;
    logic      ok;
    step_results.delete();
    case (req.op)
      OP_WRITE: begin
        adj_nbr[req.node][req.slot] = req.nbr;
        slot_loaded[req.node][req.slot] = 1'b1;
        stage_result(KIND_ACK, '0, 1'b0);
      end
      OP_DEGREE: begin
        adj_deg[req.node] = (req.deg > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : req.deg;
        stage_result(KIND_ACK, '0, 1'b0);
      end
      OP_CLEAR: begin
        visit_mark = '0;
        stage_result(KIND_ACK, '0, 1'b0);
      end
      default: begin
        ok = dfs_search(req.node, req.tgt);
        stage_result(KIND_DONE, '0, ok);
      end
    endcase
    r = step_results.pop_back();
    r.last = 1'b1;
    step_results.push_back(r);
  endfunction

  // slots written from zero upward without a gap
  function automatic int loaded_prefix(logic [NODE_W-1:0] n);
    int p;
    p = 0;
    while (p < MAX_DEGREE && slot_loaded[n][p]) p++;
    return p;
  endfunction

  // a degree that never lets a search read an unwritten slot
  function automatic logic [DEG_W-1:0] legal_degree(logic [NODE_W-1:0] n);
    int d;
    d = $urandom_range(0, loaded_prefix(n));
    if (d == MAX_DEGREE && $urandom_range(1) == 1) d = $urandom_range(MAX_DEGREE, DEG_LIMIT);
    return DEG_W'(d);
  endfunction

  function automatic path_req_t random_req(op_t op);
    path_req_t r;
    r.op = op;
    r.node = NODE_W'($urandom_range(NODE_COUNT - 1));
    r.slot = SLOT_W'($urandom_range(MAX_DEGREE - 1));
    r.nbr = NODE_W'($urandom_range(NODE_COUNT - 1));
    r.tgt = NODE_W'($urandom_range(NODE_COUNT - 1));
    r.deg = legal_degree(r.node);
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] pick_member();
    return graph_members[$urandom_range(0, graph_members.size() - 1)];
  endfunction

  // offer one item, with random gaps, and predict it on acceptance
  task automatic send_item(path_req_t req, logic typed, out_item_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req.op;
    in_tdata <= {2'b00, req.tgt, req.deg, req.nbr, req.slot, req.node};
    do @(negedge clk); while (!in_tready);
    compute_path_items(req);
    if (typed) awaited_results.push_back(typed_res);
    else foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    items_sent++;
    @(posedge clk);
  endtask

  // sender stays quiet until every expected result has come
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // load a small random graph: contiguous slots, then the degree
  task automatic build_graph();
    int        count;
    int        fan;
    path_req_t req;
    graph_members.delete();
    count = $urandom_range(3, 10);
    repeat (count) graph_members.push_back(NODE_W'($urandom_range(NODE_COUNT - 1)));
    foreach (graph_members[i]) begin
      fan = ($urandom_range(4) == 0) ? MAX_DEGREE : $urandom_range(0, 4);
      for (int s = 0; s < fan; s++) begin
        req = random_req(OP_WRITE);
        req.node = graph_members[i];
        req.slot = SLOT_W'(s);
        if ($urandom_range(3) != 0) req.nbr = pick_member();
        send_item(req, 1'b0, '0);
      end
      req = random_req(OP_DEGREE);
      req.node = graph_members[i];
      if (fan == MAX_DEGREE && $urandom_range(1) == 1) begin
        req.deg = DEG_W'($urandom_range(MAX_DEGREE, DEG_LIMIT));
      end else begin
        req.deg = DEG_W'(fan);
      end
      send_item(req, 1'b0, '0);
    end
  endtask

  // searches over the current graph, mostly from a clean slate
  task automatic search_graph(int rounds);
    path_req_t req;
    repeat (rounds) begin
      if ($urandom_range(2) != 0) send_item(random_req(OP_CLEAR), 1'b0, '0);
      req = random_req(OP_SEARCH);
      if ($urandom_range(4) != 0) req.node = pick_member();
      if ($urandom_range(4) != 0) req.tgt = pick_member();
      send_item(req, 1'b0, '0);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int quota, logic with_hold);
    int stop_at;
    stop_at = items_sent + quota;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) begin
      // receiver blocks while searches keep being offered
      build_graph();
      rx_hold_reqs++;
      search_graph(4);
      wait_results_drained();
    end
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 7) begin
        build_graph();
        search_graph($urandom_range(2, 6));
      end else begin
        // loose items of any operation
        repeat ($urandom_range(1, 5)) send_item(random_req(op_t'($urandom_range(3))), 1'b0, '0);
      end
    end
    wait_results_drained();
  endtask

  // main sequence
  initial begin : main_seq
    out_item_t typed_res;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      typed_res.kind = plan[i].kind;
      typed_res.node = '0;
      typed_res.success = plan[i].ok;
      typed_res.last = 1'b1;
      send_item(plan[i].req, plan[i].typed, typed_res);
    end
    wait_results_drained();

    run_phase(0, 0, 75, 1'b1);
    run_phase(67, 0, 65, 1'b0);
    run_phase(0, 67, 65, 1'b0);
    run_phase(26, 26, 65, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### graph_dfs_path_finder_core.f
+incdir+src
src/gdfs_pkg.sv
src/gdfs_ram.sv
src/gdfs_cmp_unit.sv
src/gdfs_out_stage.sv
src/graph_dfs_path_finder_core.sv
test/graph_dfs_path_finder_core_tb.sv
